// File: sv/stt_pkg.sv
// Shared types, token codes and keyword tables for the source text tokenizer.
package stt_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int MAX_KW_LEN_DEF  = 6;
	localparam int SLOTS           = 3;
	localparam int QUEUE_DEPTH     = 8;
	localparam int PTR_BITS        = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS        = $clog2(QUEUE_DEPTH + 1);
	localparam int NUM_KW          = 8;

	typedef enum logic [3:0] {
		M_IDLE,
		M_COMMENT,
		M_NUM_INT,
		M_NUM_DOT,
		M_NUM_FRAC,
		M_IDENT,
		M_EQ,
		M_LT,
		M_GT,
		M_BANG
	} scan_mode_t;

	localparam logic [4:0] K_EOF     = 5'd0;
	localparam logic [4:0] K_NEWLINE = 5'd1;
	localparam logic [4:0] K_PLUS    = 5'd2;
	localparam logic [4:0] K_MINUS   = 5'd3;
	localparam logic [4:0] K_STAR    = 5'd4;
	localparam logic [4:0] K_SLASH   = 5'd5;
	localparam logic [4:0] K_PCT     = 5'd6;
	localparam logic [4:0] K_LPAREN  = 5'd7;
	localparam logic [4:0] K_RPAREN  = 5'd8;
	localparam logic [4:0] K_LBRACE  = 5'd9;
	localparam logic [4:0] K_RBRACE  = 5'd10;
	localparam logic [4:0] K_COMMA   = 5'd11;
	localparam logic [4:0] K_ASSIGN  = 5'd12;
	localparam logic [4:0] K_EQ      = 5'd13;
	localparam logic [4:0] K_NEQ     = 5'd14;
	localparam logic [4:0] K_LT      = 5'd15;
	localparam logic [4:0] K_LTE     = 5'd16;
	localparam logic [4:0] K_GT      = 5'd17;
	localparam logic [4:0] K_GTE     = 5'd18;
	localparam logic [4:0] K_NUMBER  = 5'd19;
	localparam logic [4:0] K_IDENT   = 5'd20;
	localparam logic [4:0] K_KW_BASE = 5'd21;
	localparam logic [4:0] K_ERROR   = 5'd29;

	// first character in the low byte
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'h0000_6573_6c65,
		48'h0065_736c_6166,
		48'h0000_0000_6e66,
		48'h0000_0000_6669,
		48'h0000_0074_656c,
		48'h6e72_7574_6572,
		48'h0000_6575_7274,
		48'h0065_6c69_6877
	};
	localparam logic [15:0] KW_LEN [NUM_KW] = '{
		16'd4, 16'd5, 16'd2, 16'd2, 16'd3, 16'd6, 16'd4, 16'd5
	};

	typedef struct packed {
		logic [4:0]  kind;
		logic [23:0] offset;
		logic [15:0] len;
		logic [19:0] line;
		logic [15:0] column;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [SLOTS-1:0]         vld;
		token_t [SLOTS-1:0]       tok;
	} push_t;

	function automatic logic [4:0] kw_lookup(input logic [47:0] chars, input logic [15:0] len);
		logic [4:0] kind;
		kind = K_IDENT;
		for (int k = 0; k < NUM_KW; k++) begin
			if (len == KW_LEN[k] && chars == KW_TEXT[k]) begin
				kind = K_KW_BASE + 5'(k);
			end
		end
		return kind;
	endfunction

endpackage

// File: sv/stt_scan.sv
// Scanner: mode and position state, and the tokens that one source word produces.
module stt_scan #(
	parameter int OFFSET_BITS     = 24,
	parameter int MAX_KEYWORD_LEN = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_s1,
	input  logic [7:0]    ch_s1,
	output stt_pkg::push_t push
);
	import stt_pkg::*;

	localparam int KW_BITS = 8 * MAX_KEYWORD_LEN;
	localparam logic [32:0] OFF_MAX33 = (33'd1 << OFFSET_BITS) - 33'd1;
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

	scan_mode_t             mode_q, mode_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [19:0]            line_q, line_d;
	logic [15:0]            col_q, col_d;
	logic [OFFSET_BITS-1:0] ts_off_q, ts_off_d;
	logic [19:0]            ts_line_q, ts_line_d;
	logic [15:0]            ts_col_q, ts_col_d;
	logic [15:0]            len_q, len_d;
	logic [KW_BITS-1:0]     kw_q, kw_d;

	logic is_dig, is_alp, is_idc, is_nul, is_nl, is_dot, is_eq, absorb, flush;
	logic [32:0] dot_sum;
	logic [16:0] dot_col;
	logic [OFFSET_BITS-1:0] dot_off;

	function automatic logic [23:0] to24(input logic [OFFSET_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[23:0];
	endfunction

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] b);
		logic [16:0] s;
		s = {1'b0, a} + 17'(b);
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic scan_mode_t open_mode(input logic [7:0] c);
		scan_mode_t m;
		m = M_IDLE;
		if (c == "#") m = M_COMMENT;
		else if (c >= "0" && c <= "9") m = M_NUM_INT;
		else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") m = M_IDENT;
		else if (c == "=") m = M_EQ;
		else if (c == "<") m = M_LT;
		else if (c == ">") m = M_GT;
		else if (c == "!") m = M_BANG;
		return m;
	endfunction

	assign is_dig = ch_s1 >= "0" && ch_s1 <= "9";
	assign is_alp = (ch_s1 >= "a" && ch_s1 <= "z") || (ch_s1 >= "A" && ch_s1 <= "Z");
	assign is_idc = is_dig || is_alp || ch_s1 == "_";
	assign is_nul = ch_s1 == 8'd0;
	assign is_nl  = ch_s1 == 8'h0a;
	assign is_dot = ch_s1 == ".";
	assign is_eq  = ch_s1 == "=";

	always_comb begin
		case (mode_q)
			M_COMMENT:  absorb = !is_nl;
			M_NUM_INT:  absorb = is_dig || is_dot;
			M_NUM_DOT:  absorb = is_dig;
			M_NUM_FRAC: absorb = is_dig;
			M_IDENT:    absorb = is_idc;
			M_EQ, M_LT, M_GT, M_BANG: absorb = is_eq;
			default:    absorb = 1'b0;
		endcase
		if (is_nul) absorb = 1'b0;
	end

	assign flush = vld_s1 && !absorb;

	// next mode
	always_comb begin
		mode_d = mode_q;
		if (vld_s1) begin
			if (is_nul) begin
				mode_d = M_IDLE;
			end else if (absorb) begin
				case (mode_q)
					M_NUM_INT: if (is_dot) mode_d = M_NUM_DOT;
					M_NUM_DOT: mode_d = M_NUM_FRAC;
					M_EQ, M_LT, M_GT, M_BANG: mode_d = M_IDLE;
					default: mode_d = mode_q;
				endcase
			end else begin
				mode_d = open_mode(ch_s1);
			end
		end
	end

	assign dot_sum = 33'(ts_off_q) + 33'(len_q);
	assign dot_off = (dot_sum > OFF_MAX33) ? OFF_MAX : dot_sum[OFFSET_BITS-1:0];
	assign dot_col = {1'b0, ts_col_q} + {1'b0, len_q};

	// tokens
	always_comb begin
		push = '0;
		push.tok[0].offset = to24(ts_off_q);
		push.tok[0].line   = ts_line_q;
		push.tok[0].column = ts_col_q;
		push.tok[0].len    = 16'd1;
		case (mode_q)
			M_NUM_INT, M_NUM_DOT, M_NUM_FRAC: begin
				push.tok[0].kind = K_NUMBER;
				push.tok[0].len  = len_q;
			end
			M_IDENT: begin
				push.tok[0].kind = kw_lookup(kw_q[47:0], len_q);
				push.tok[0].len  = len_q;
			end
			M_EQ:    push.tok[0].kind = absorb ? K_EQ  : K_ASSIGN;
			M_LT:    push.tok[0].kind = absorb ? K_LTE : K_LT;
			M_GT:    push.tok[0].kind = absorb ? K_GTE : K_GT;
			M_BANG:  push.tok[0].kind = absorb ? K_NEQ : K_ERROR;
			default: push.tok[0].kind = K_ERROR;
		endcase
		if (absorb && (mode_q == M_EQ || mode_q == M_LT || mode_q == M_GT
				|| mode_q == M_BANG)) begin
			push.tok[0].len = 16'd2;
			push.vld[0] = vld_s1;
		end else begin
			push.vld[0] = flush && mode_q != M_IDLE && mode_q != M_COMMENT;
		end

		push.tok[1].kind   = K_ERROR;
		push.tok[1].offset = to24(dot_off);
		push.tok[1].len    = 16'd1;
		push.tok[1].line   = ts_line_q;
		push.tok[1].column = dot_col[16] ? 16'hFFFF : dot_col[15:0];
		push.vld[1]        = flush && mode_q == M_NUM_DOT;

		push.tok[2].offset = to24(off_q);
		push.tok[2].line   = line_q;
		push.tok[2].column = col_q;
		push.tok[2].len    = 16'd1;
		push.tok[2].kind   = K_ERROR;
		push.vld[2]        = flush;
		case (ch_s1)
			8'h00: begin
				push.tok[2].kind = K_EOF;
				push.tok[2].len  = 16'd0;
			end
			8'h0a:   push.tok[2].kind = K_NEWLINE;
			"+":     push.tok[2].kind = K_PLUS;
			"-":     push.tok[2].kind = K_MINUS;
			"*":     push.tok[2].kind = K_STAR;
			"/":     push.tok[2].kind = K_SLASH;
			"%":     push.tok[2].kind = K_PCT;
			"(":     push.tok[2].kind = K_LPAREN;
			")":     push.tok[2].kind = K_RPAREN;
			"{":     push.tok[2].kind = K_LBRACE;
			"}":     push.tok[2].kind = K_RBRACE;
			",":     push.tok[2].kind = K_COMMA;
			" ", 8'h09, 8'h0d, "#", "=", "<", ">", "!": push.vld[2] = 1'b0;
			default: begin
				if (is_idc) push.vld[2] = 1'b0;
			end
		endcase

		push.tok[2].last = push.vld[2];
		push.tok[1].last = push.vld[1] && !push.vld[2];
		push.tok[0].last = push.vld[0] && !push.vld[1] && !push.vld[2];
	end

	// position and pending token
	always_comb begin
		off_d     = off_q;
		line_d    = line_q;
		col_d     = col_q;
		ts_off_d  = ts_off_q;
		ts_line_d = ts_line_q;
		ts_col_d  = ts_col_q;
		len_d     = len_q;
		kw_d      = kw_q;
		if (vld_s1) begin
			if (is_nul) begin
				off_d     = '0;
				line_d    = 20'd1;
				col_d     = 16'd1;
				ts_off_d  = '0;
				ts_line_d = 20'd1;
				ts_col_d  = 16'd1;
				len_d     = 16'd0;
				kw_d      = '0;
			end else begin
				if (absorb) begin
					case (mode_q)
						M_NUM_INT:  if (is_dig) len_d = sat_add(len_q, 2'd1);
						M_NUM_DOT:  len_d = sat_add(len_q, 2'd2);
						M_NUM_FRAC: len_d = sat_add(len_q, 2'd1);
						M_IDENT: begin
							for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
								if (len_q == 16'(i)) kw_d[8*i +: 8] = ch_s1;
							end
							len_d = sat_add(len_q, 2'd1);
						end
						default: len_d = len_q;
					endcase
				end else begin
					ts_off_d  = off_q;
					ts_line_d = line_q;
					ts_col_d  = col_q;
					len_d     = 16'd1;
					kw_d      = KW_BITS'(ch_s1);
				end
				if (off_q != OFF_MAX) off_d = off_q + 1'b1;
				if (is_nl) begin
					if (line_q != 20'hFFFFF) line_d = line_q + 1'b1;
					col_d = 16'd1;
				end else if (col_q != 16'hFFFF) begin
					col_d = col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			off_q     <= '0;
			line_q    <= 20'd1;
			col_q     <= 16'd1;
			ts_off_q  <= '0;
			ts_line_q <= 20'd1;
			ts_col_q  <= 16'd1;
			len_q     <= 16'd0;
			kw_q      <= '0;
		end else begin
			mode_q    <= mode_d;
			off_q     <= off_d;
			line_q    <= line_d;
			col_q     <= col_d;
			ts_off_q  <= ts_off_d;
			ts_line_q <= ts_line_d;
			ts_col_q  <= ts_col_d;
			len_q     <= len_d;
			kw_q      <= kw_d;
		end
	end

endmodule

// File: sv/stt_fifo.sv
// Token queue: takes up to 3 tokens a cycle in order, gives one a cycle on pop.
module stt_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stt_pkg::push_t                push,
	input  logic                          pop,
	output stt_pkg::token_t               head,
	output logic [stt_pkg::CNT_BITS-1:0]  count
);
	import stt_pkg::*;

	token_t              mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [PTR_BITS-1:0] pos [SLOTS];
	logic [PTR_BITS-1:0] wr_d;

	always_comb begin
		wr_d = wr_q;
		for (int i = 0; i < SLOTS; i++) begin
			pos[i] = wr_d;
			if (push.vld[i]) wr_d = wr_d + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (push.vld[i]) mem_q[pos[i]] <= push.tok[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_d;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_BITS'($countones(push.vld)) - CNT_BITS'(pop);
		end
	end

	assign head  = mem_q[rd_q];
	assign count = cnt_q;

endmodule

// File: sv/source_text_tokenizer.sv
// Top level of the source text tokenizer: input register, scanner and token queue.
//
//  channel | direction | handshake         | payload
//  source  | in        | src_valid/src_stall | ch
//  token   | out       | tok_valid/tok_stall | token_kind, start_offset, token_length,
//          |           |                   | line_number, column_number, last_of_run
//
// One source word per cycle unless src_stall: a word is registered, then scanned
// in the next cycle. A word yields up to three tokens; the queue drains one token
// per cycle unless tok_stall, so src_stall rises only when tokens pile up faster
// than the token side takes them. Tokens go through the input register and queue.
// Reset returns mode and position to line 1, column 1, offset 0 and empties the queue.
module source_text_tokenizer #(
	parameter int OFFSET_BITS     = stt_pkg::OFFSET_BITS_DEF,
	parameter int MAX_KEYWORD_LEN = stt_pkg::MAX_KW_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  ch,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [4:0]  token_kind,
	output logic [23:0] start_offset,
	output logic [15:0] token_length,
	output logic [19:0] line_number,
	output logic [15:0] column_number,
	output logic        last_of_run
);
	import stt_pkg::*;

	logic                vld_s1;
	logic [7:0]          ch_s1;
	push_t               push;
	token_t              head;
	logic [CNT_BITS-1:0] count;
	logic [CNT_BITS:0]   load;

	// hold off new words unless the queue has room for this word and the one in flight
	assign load      = {1'b0, count} + (vld_s1 ? (CNT_BITS+1)'(SLOTS) : '0);
	assign src_stall = load > (CNT_BITS+1)'(QUEUE_DEPTH - SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= src_valid && !src_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) ch_s1 <= ch;
	end

	stt_scan #(
		.OFFSET_BITS     (OFFSET_BITS),
		.MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.ch_s1  (ch_s1),
		.push   (push)
	);

	stt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (tok_valid && !tok_stall),
		.head   (head),
		.count  (count)
	);

	assign tok_valid     = count != '0;
	assign token_kind    = head.kind;
	assign start_offset  = head.offset;
	assign token_length  = head.len;
	assign line_number   = head.line;
	assign column_number = head.column;
	assign last_of_run   = head.last;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the source text tokenizer: byte driver, token monitor, scanner model.
module tb_top;
	import stt_pkg::*;

	localparam logic [7:0]  CH_NUL = 8'h00;
	localparam logic [7:0]  CH_TAB = 8'h09;
	localparam logic [7:0]  CH_LF  = 8'h0A;
	localparam logic [7:0]  CH_CR  = 8'h0D;
	localparam longint unsigned OFF_MAX = (64'd1 << OFFSET_BITS_DEF) - 1;
	localparam logic [19:0] LINE_MAX = 20'hFFFFF;
	localparam logic [15:0] COL_MAX  = 16'hFFFF;
	localparam int unsigned LEN_MAX  = 65535;
	localparam int unsigned RANDOM_WORDS = 86;
	localparam int unsigned LONG_HOLD    = 600;
	localparam int unsigned WATCHDOG     = 3000;
	localparam int unsigned DRAIN        = 20;

	typedef struct {
		logic [7:0]  c;
		int unsigned gap;
	} src_word_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic [7:0]  ch = 8'h00;
	logic        tok_valid;
	logic        tok_stall = 1'b1;
	logic [4:0]  token_kind;
	logic [23:0] start_offset;
	logic [15:0] token_length;
	logic [19:0] line_number;
	logic [15:0] column_number;
	logic        last_of_run;

	source_text_tokenizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.ch           (ch),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.start_offset (start_offset),
		.token_length (token_length),
		.line_number  (line_number),
		.column_number(column_number),
		.last_of_run  (last_of_run)
	);

	string keyword_names [8] = '{"else", "false", "fn", "if", "let", "return", "true", "while"};
	string operator_texts [18] = '{"+", "-", "*", "/", "%", "(", ")", "{", "}", ",",
		"=", "==", "!=", "<", "<=", ">", ">=", "!"};
	string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	src_word_t   src_words [$];
	token_t      expected_tokens [$];
	int unsigned words_total = 0;
	int unsigned words_taken = 0;
	int unsigned tokens_seen = 0;
	int unsigned mismatches = 0;
	int unsigned stuck = 0;
	int unsigned stalled_cycles = 0;
	bit [31:0]   kinds_seen = '0;
	logic        src_taken = 1'b0;
	logic        tok_taken = 1'b0;
	int unsigned rx_wait = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	scan_mode_t  lex_mode = M_IDLE;
	logic [23:0] cur_off = '0;
	logic [19:0] cur_ln = 20'd1;
	logic [15:0] cur_col = 16'd1;
	logic [23:0] pend_off = '0;
	logic [19:0] pend_ln = 20'd1;
	logic [15:0] pend_col = 16'd1;
	int unsigned pend_len = 0;
	logic [47:0] pend_chars = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic string tok_str(token_t t);
		return $sformatf("kind %0d off %0d len %0d line %0d col %0d last %0d",
			t.kind, t.offset, t.len, t.line, t.column, t.last);
	endfunction

	function automatic void add_token(logic [4:0] kind, logic [23:0] off, logic [15:0] len,
		logic [19:0] ln, logic [15:0] col);
		token_t t;
		t.kind = kind;
		t.offset = off;
		t.len = len;
		t.line = ln;
		t.column = col;
		t.last = 1'b0;
		expected_tokens.push_back(t);
	endfunction

	function automatic void add_pending(logic [4:0] kind, int unsigned len);
		add_token(kind, pend_off, 16'(len), pend_ln, pend_col);
	endfunction

	function automatic void grow_token(int unsigned by);
		pend_len = pend_len + by;
		if (pend_len > LEN_MAX) pend_len = LEN_MAX;
	endfunction

	function automatic logic [4:0] ident_kind();
		logic [4:0] kind;
		bit same;
		kind = K_IDENT;
		for (int k = 0; k < 8; k++) begin
			if (keyword_names[k].len() == pend_len) begin
				same = 1'b1;
				for (int i = 0; i < keyword_names[k].len(); i++)
					if (pend_chars[8*i +: 8] != keyword_names[k][i]) same = 1'b0;
				if (same) kind = K_KW_BASE + 5'(k);
			end
		end
		return kind;
	endfunction

	function automatic void flush_pending();
		longint unsigned dot_off;
		int unsigned dot_col;
		case (lex_mode)
			M_NUM_INT, M_NUM_FRAC: add_pending(K_NUMBER, pend_len);
			M_NUM_DOT: begin
				add_pending(K_NUMBER, pend_len);
				dot_off = pend_off + pend_len;
				if (dot_off > OFF_MAX) dot_off = OFF_MAX;
				dot_col = pend_col + pend_len;
				if (dot_col > COL_MAX) dot_col = COL_MAX;
				add_token(K_ERROR, 24'(dot_off), 16'd1, pend_ln, 16'(dot_col));
			end
			M_IDENT: add_pending(ident_kind(), pend_len);
			M_EQ:    add_pending(K_ASSIGN, 1);
			M_LT:    add_pending(K_LT, 1);
			M_GT:    add_pending(K_GT, 1);
			M_BANG:  add_pending(K_ERROR, 1);
			default: ;
		endcase
		lex_mode = M_IDLE;
	endfunction

	function automatic bit extend_pending(logic [7:0] c);
		case (lex_mode)
			M_COMMENT: return c != CH_LF;
			M_NUM_INT: begin
				if (is_digit(c)) begin
					grow_token(1);
					return 1'b1;
				end
				if (c == ".") begin
					lex_mode = M_NUM_DOT;
					return 1'b1;
				end
				return 1'b0;
			end
			M_NUM_DOT: begin
				if (!is_digit(c)) return 1'b0;
				grow_token(2);
				lex_mode = M_NUM_FRAC;
				return 1'b1;
			end
			M_NUM_FRAC: begin
				if (!is_digit(c)) return 1'b0;
				grow_token(1);
				return 1'b1;
			end
			M_IDENT: begin
				if (!(is_letter(c) || is_digit(c) || c == "_")) return 1'b0;
				if (pend_len < MAX_KW_LEN_DEF) pend_chars[8*pend_len +: 8] = c;
				grow_token(1);
				return 1'b1;
			end
			M_EQ, M_LT, M_GT, M_BANG: begin
				if (c != "=") return 1'b0;
				case (lex_mode)
					M_EQ:    add_pending(K_EQ, 2);
					M_LT:    add_pending(K_LTE, 2);
					M_GT:    add_pending(K_GTE, 2);
					default: add_pending(K_NEQ, 2);
				endcase
				lex_mode = M_IDLE;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void open_token(logic [7:0] c);
		pend_off = cur_off;
		pend_ln = cur_ln;
		pend_col = cur_col;
		pend_len = 1;
		pend_chars = 48'(c);
		case (c)
			" ", CH_TAB, CH_CR: ;
			"#":   lex_mode = M_COMMENT;
			CH_LF: add_pending(K_NEWLINE, 1);
			"+":   add_pending(K_PLUS, 1);
			"-":   add_pending(K_MINUS, 1);
			"*":   add_pending(K_STAR, 1);
			"/":   add_pending(K_SLASH, 1);
			"%":   add_pending(K_PCT, 1);
			"(":   add_pending(K_LPAREN, 1);
			")":   add_pending(K_RPAREN, 1);
			"{":   add_pending(K_LBRACE, 1);
			"}":   add_pending(K_RBRACE, 1);
			",":   add_pending(K_COMMA, 1);
			"=":   lex_mode = M_EQ;
			"<":   lex_mode = M_LT;
			">":   lex_mode = M_GT;
			"!":   lex_mode = M_BANG;
			default: begin
				if (is_digit(c)) lex_mode = M_NUM_INT;
				else if (is_letter(c) || c == "_") lex_mode = M_IDENT;
				else add_pending(K_ERROR, 1);
			end
		endcase
	endfunction

	function automatic void predict_word(logic [7:0] c);
		int unsigned before_cnt;
		before_cnt = expected_tokens.size();
		if (c == CH_NUL) begin
			if (lex_mode == M_COMMENT) lex_mode = M_IDLE;
			flush_pending();
			add_token(K_EOF, cur_off, 16'd0, cur_ln, cur_col);
			lex_mode = M_IDLE;
			cur_off = '0;
			cur_ln = 20'd1;
			cur_col = 16'd1;
		end else begin
			if (!extend_pending(c)) begin
				flush_pending();
				open_token(c);
			end
			if (cur_off < OFF_MAX) cur_off = cur_off + 1'b1;
			if (c == CH_LF) begin
				if (cur_ln < LINE_MAX) cur_ln = cur_ln + 1'b1;
				cur_col = 16'd1;
			end else if (cur_col < COL_MAX) begin
				cur_col = cur_col + 1'b1;
			end
		end
		if (expected_tokens.size() > before_cnt)
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endfunction

	function automatic void push_word(logic [7:0] c, bit calm);
		src_word_t w;
		w.c = c;
		w.gap = calm ? 0 : $urandom_range(0, 19);
		src_words.push_back(w);
		words_total++;
	endfunction

	function automatic void push_text(string s, bit calm);
		for (int i = 0; i < s.len(); i++) push_word(s[i], calm);
	endfunction

	function automatic void add_fragment(bit calm);
		case ($urandom_range(0, 9))
			0: push_text(keyword_names[$urandom_range(0, 7)], calm);
			1: begin
				push_word(word_chars[$urandom_range(0, 52)], calm);
				repeat ($urandom_range(0, 7)) push_word(word_chars[$urandom_range(0, 62)], calm);
			end
			2: begin
				repeat ($urandom_range(1, 4)) push_word(8'("0" + $urandom_range(0, 9)), calm);
				if ($urandom_range(0, 1)) begin
					push_word(".", calm);
					if ($urandom_range(0, 9) < 7)
						repeat ($urandom_range(1, 3)) push_word(8'("0" + $urandom_range(0, 9)), calm);
				end
			end
			3: push_text(operator_texts[$urandom_range(0, 17)], calm);
			4: begin
				case ($urandom_range(0, 2))
					0: push_word(" ", calm);
					1: push_word(CH_TAB, calm);
					default: push_word(CH_CR, calm);
				endcase
			end
			5: push_word(CH_LF, calm);
			6: begin
				push_word("#", calm);
				repeat ($urandom_range(0, 5)) push_word(8'($urandom_range(1, 255)), calm);
			end
			7: push_word(8'($urandom_range(1, 255)), calm);
			8: begin
				if ($urandom_range(0, 2) == 0) push_word(CH_NUL, calm);
				else push_word(" ", calm);
			end
			default: push_word(" ", calm);
		endcase
	endfunction

	// source driver: hold while stalled, idle out each word's gap, then offer it
	always @(negedge clk) begin
		if (arst_n && !(src_valid && !src_taken)) begin
			if (src_words.size() > 0 && src_words[0].gap > 0) begin
				src_valid <= 1'b0;
				src_words[0].gap = src_words[0].gap - 1;
			end else if (src_words.size() > 0) begin
				src_valid <= 1'b1;
				ch <= src_words[0].c;
				void'(src_words.pop_front());
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// token receiver: random stall per token, one long hold to back up the block
	always @(negedge clk) begin
		int unsigned w;
		if (arst_n) begin
			if (!hold_done && tokens_seen >= 20) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				tok_stall <= 1'b1;
				hold_left--;
			end else if (tok_taken) begin
				w = (tokens_seen % 64 < 16) ? 0 : $urandom_range(0, 19);
				tok_stall <= (w != 0);
				rx_wait = (w != 0) ? w - 1 : 0;
			end else if (rx_wait > 0) begin
				tok_stall <= 1'b1;
				rx_wait--;
			end else begin
				tok_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		token_t got;
		token_t want;
		if (arst_n) begin
			src_taken <= src_valid && !src_stall;
			tok_taken <= tok_valid && !tok_stall;
			if (src_valid && src_stall) stalled_cycles++;
			if ((src_valid && !src_stall) || (tok_valid && !tok_stall)) stuck = 0;
			else stuck++;
			if (tok_valid && !tok_stall) begin
				tokens_seen++;
				kinds_seen[token_kind] = 1'b1;
				got.kind = token_kind;
				got.offset = start_offset;
				got.len = token_length;
				got.line = line_number;
				got.column = column_number;
				got.last = last_of_run;
				if (expected_tokens.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected token: %s", tok_str(got));
				end else begin
					want = expected_tokens.pop_front();
					if (got.kind !== want.kind || got.offset !== want.offset ||
						got.len !== want.len || got.line !== want.line ||
						got.column !== want.column || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("token %0d mismatch: expected %s, got %s",
								tokens_seen, tok_str(want), tok_str(got));
					end
				end
			end
			if (src_valid && !src_stall) begin
				predict_word(ch);
				words_taken++;
			end
		end
	end

	initial begin
		bit calm;
		int unsigned first_random;
		// number then letters, lone bang, stray dot, dot before '=', comment with high byte
		push_text("12ab!.3.==", 1'b0);
		push_word(CH_TAB, 1'b0);
		push_word("#", 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(CH_LF, 1'b0);
		push_word(8'h80, 1'b0);
		push_word("<", 1'b0);
		push_word(CH_CR, 1'b0);
		// number waiting on its dot at end of source, then comment at end of source
		push_text("9.", 1'b0);
		push_word(CH_NUL, 1'b0);
		push_text("#x", 1'b0);
		push_word(CH_NUL, 1'b0);
		first_random = words_total;
		while (words_total < first_random + RANDOM_WORDS) begin
			calm = ($urandom_range(0, 3) == 0);
			add_fragment(calm);
		end
		push_word(CH_NUL, 1'b0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (!(words_taken == words_total && expected_tokens.size() == 0) && stuck < WATCHDOG)
			@(posedge clk);
		if (stuck >= WATCHDOG) begin
			$display("timeout after %0d idle cycles, %0d tokens still expected",
				stuck, expected_tokens.size());
			$display("FAILED: results differ");
		end else begin
			repeat (DRAIN) @(posedge clk);
			$display("Scanned %0d source words into %0d tokens, %0d mismatches",
				words_taken, tokens_seen, mismatches);
			$display("Saw %0d of 30 token kinds, %0d cycles of source backpressure",
				$countones(kinds_seen), stalled_cycles);
			if (mismatches == 0) $display("PASSED: all results match");
			else $display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: source_text_tokenizer.f
sv/stt_pkg.sv
sv/stt_scan.sv
sv/stt_fifo.sv
sv/source_text_tokenizer.sv
dv/tb_top.sv
